>>> src/dibc_pkg.sv
// Shared constants and codes for the idle blanking controller.
`default_nettype none

package dibc_pkg;

    // Event kinds carried by the kind field
    localparam logic [2:0] KIND_IDLE_CHECK = 3'd0;
    localparam logic [2:0] KIND_USER_INPUT = 3'd1;
    localparam logic [2:0] KIND_BLANK_START = 3'd2;
    localparam logic [2:0] KIND_BLANK_STOP = 3'd3;
    localparam logic [2:0] KIND_IDLE_RESET = 3'd4;
    localparam logic [2:0] KIND_QUIT_REQ = 3'd5;

    // Configuration register indexes
    localparam logic [2:0] CFG_FADE_SECONDS = 3'd0;
    localparam logic [2:0] CFG_BLANK_NOW_CORNER = 3'd1;
    localparam logic [2:0] CFG_NEVER_BLANK_CORNER = 3'd2;
    localparam logic [2:0] CFG_SCREEN_RIGHT = 3'd3;
    localparam logic [2:0] CFG_SCREEN_BOTTOM = 3'd4;

    // Corner codes, unsigned 3 bits; all ones means no corner
    localparam logic [2:0] CORNER_NONE = 3'b111;
    localparam logic [2:0] CORNER_TL = 3'd0;
    localparam logic [2:0] CORNER_TR = 3'd1;
    localparam logic [2:0] CORNER_BR = 3'd2;
    localparam logic [2:0] CORNER_BL = 3'd3;

    localparam int unsigned FADE_US_W = 36;
    localparam logic [19:0] US_PER_S = 20'd1000000;
    localparam logic [63:0] HOT_CORNER_US = 64'd2000000;
    localparam logic [63:0] WAKE_GAP_US = 64'd500000;
    localparam logic [62:0] CORNER_HOLDOFF_US = 63'd5000000;
    localparam logic [11:0] CORNER_SIZE = 12'd3;
    localparam logic [7:0] TAB_CODE = 8'd9;

    localparam logic [11:0] SCREEN_RIGHT_RST = 12'd639;
    localparam logic [11:0] SCREEN_BOTTOM_RST = 12'd479;
    localparam logic [11:0] POINTER_RST = 12'd10;

    // Corner the pointer rests in, or none while the time is within the holdoff
    function automatic logic [2:0] pointer_corner(
        input logic [62:0] now,
        input logic [11:0] col,
        input logic [11:0] row,
        input logic [11:0] right,
        input logic [11:0] bottom
    );
        logic x_lo;
        logic y_lo;
        logic x_hi;
        logic y_hi;
        logic [2:0] c;
        x_lo = col < CORNER_SIZE;
        y_lo = row < CORNER_SIZE;
        // col > right - 3 rewritten without a signed subtract
        x_hi = ({1'b0, col} + {1'b0, CORNER_SIZE}) > {1'b0, right};
        y_hi = ({1'b0, row} + {1'b0, CORNER_SIZE}) > {1'b0, bottom};
        if (now < CORNER_HOLDOFF_US)
            c = CORNER_NONE;
        else if (x_lo && y_lo)
            c = CORNER_TL;
        else if (x_hi && y_lo)
            c = CORNER_TR;
        else if (x_hi && y_hi)
            c = CORNER_BR;
        else if (x_lo && y_hi)
            c = CORNER_BL;
        else
            c = CORNER_NONE;
        return c;
    endfunction

endpackage

`default_nettype wire

>>> src/display_idle_blank_controller.sv
// Idle blanking controller: event register, decision logic and result register.
//
// Event words enter on in_valid/in_stall, one result word leaves on
// out_valid/out_stall for every event, in order. A word is taken at a rising
// edge with valid high and stall low. The event is captured in an input
// register, decided by one pass of compare and subtract logic, and written
// with the updated blanker state into the result register, from which it
// can leave; while the receiver does not stall, one event per cycle is
// sustained.
// The idle-timeout product is formed when fade_seconds is written, so the
// per-event path is one 64-bit subtract and compare.
// When the receiver stalls, the result register holds; the input register
// still takes one more event, and in_stall rises only when both are full.
// Configuration writes (cfg_valid/cfg_ready, cfg_ready always high) go to the register given by
// cfg_index; the user must make them while no event is in flight, which the block does not enforce.
// Reset clears the blanker state, sets the pointer to (10,10), the frame to
// 639 x 479, both corners to none and the idle timeout to off, and empties
// both registers.
`default_nettype none

module display_idle_blank_controller
    import dibc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // event channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [62:0] time_us,
    input  wire logic [11:0] pointer_x,
    input  wire logic [11:0] pointer_y,
    input  wire logic        is_mouse_move,
    input  wire logic        has_modifiers,
    input  wire logic        ctrl_held,
    input  wire logic        cmd_held,
    input  wire logic        has_char,
    input  wire logic [7:0]  char_code,
    input  wire logic        is_blanker_app,
    input  wire logic [30:0] program_id,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             launch_blanker,
    output logic             pass_input,
    output logic             send_quit,
    output logic             quit_status,
    output logic             blanking,
    output logic [62:0]      idle_time_us,
    // configuration channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    // configuration
    logic [FADE_US_W-1:0] fade_us_reg;
    logic [2:0]           blank_corner_reg;
    logic [2:0]           never_corner_reg;
    logic [11:0]          screen_right_reg;
    logic [11:0]          screen_bottom_reg;

    // blanker state
    logic        blanking_reg, blanking_next;
    logic [62:0] activity_reg, activity_next;
    logic [62:0] wake_reg, wake_next;
    logic [11:0] col_reg, col_next;
    logic [11:0] row_reg, row_next;
    logic [30:0] blanker_id_reg, blanker_id_next;

    // input register
    logic        ev_valid_reg;
    logic [2:0]  ev_kind_reg;
    logic [62:0] ev_time_reg;
    logic [11:0] ev_x_reg;
    logic [11:0] ev_y_reg;
    logic        ev_move_reg;
    logic        ev_mods_reg;
    logic        ev_ctrl_reg;
    logic        ev_cmd_reg;
    logic        ev_has_char_reg;
    logic [7:0]  ev_char_reg;
    logic        ev_blanker_reg;
    logic [30:0] ev_pid_reg;

    // result register
    logic        out_valid_reg;
    logic        launch_reg, launch_next;
    logic        pass_reg, pass_next;
    logic        quit_reg, quit_next;
    logic        qstat_reg, qstat_next;
    logic [62:0] idle_reg, idle_next;

    logic               advance;
    logic               fire;
    logic               in_take;
    logic signed [63:0] since_act;
    logic [2:0]         corner;
    logic               swallow;
    logic               wake_due;
    logic               activity_hit;

    assign advance  = !out_valid_reg || !out_stall;
    assign fire     = ev_valid_reg && advance;
    assign in_stall = ev_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign since_act = $signed({1'b0, ev_time_reg}) - $signed({1'b0, activity_reg});
    assign corner = pointer_corner(ev_time_reg, col_reg, row_reg,
                                   screen_right_reg, screen_bottom_reg);
    assign wake_due = ({1'b0, wake_reg} + WAKE_GAP_US) < {1'b0, ev_time_reg};

    always_comb
    begin
        blanking_next   = blanking_reg;
        activity_next   = activity_reg;
        wake_next       = wake_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        blanker_id_next = blanker_id_reg;
        launch_next     = 1'b0;
        pass_next       = 1'b0;
        quit_next       = 1'b0;
        qstat_next      = 1'b0;
        swallow         = 1'b0;
        activity_hit    = 1'b0;
        case (ev_kind_reg)
            KIND_IDLE_CHECK:
            begin
                if (!blanking_reg && (never_corner_reg == CORNER_NONE
                                      || corner != never_corner_reg))
                begin
                    if (fade_us_reg != '0
                        && since_act > $signed({28'd0, fade_us_reg}))
                        launch_next = 1'b1;
                    if (blank_corner_reg != CORNER_NONE && corner == blank_corner_reg
                        && since_act > $signed(HOT_CORNER_US))
                        launch_next = 1'b1;
                end
            end
            KIND_USER_INPUT:
            begin
                activity_hit  = 1'b1;
                activity_next = ev_time_reg;
                if (blanking_reg)
                begin
                    // drop the key combinations that switch blankers
                    if (ev_mods_reg)
                    begin
                        if (ev_ctrl_reg && ev_cmd_reg)
                            swallow = 1'b1;
                        else if (ev_has_char_reg && (ev_ctrl_reg || ev_cmd_reg)
                                 && ev_char_reg == TAB_CODE)
                            swallow = 1'b1;
                    end
                    if (!swallow && wake_due)
                    begin
                        quit_next = 1'b1;
                        wake_next = ev_time_reg;
                    end
                end
                if (!swallow)
                begin
                    if (ev_move_reg)
                    begin
                        col_next = ev_x_reg;
                        row_next = ev_y_reg;
                    end
                    pass_next = 1'b1;
                end
            end
            KIND_BLANK_START:
            begin
                if (!blanking_reg && ev_blanker_reg)
                begin
                    blanking_next   = 1'b1;
                    blanker_id_next = ev_pid_reg;
                    wake_next       = ev_time_reg;
                end
            end
            KIND_BLANK_STOP:
            begin
                if (ev_blanker_reg && ev_pid_reg == blanker_id_reg)
                    blanking_next = 1'b0;
            end
            KIND_IDLE_RESET:
            begin
                activity_hit  = 1'b1;
                activity_next = ev_time_reg;
            end
            KIND_QUIT_REQ:
            begin
                if (blanking_reg)
                begin
                    activity_hit  = 1'b1;
                    activity_next = ev_time_reg;
                    quit_next     = 1'b1;
                end
                else
                begin
                    qstat_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        // idle time after the item: zero once activity moves to now or when no time has passed since it
        if (activity_hit || since_act <= 64'sd0)
            idle_next = '0;
        else
            idle_next = since_act[62:0];
    end

    // configuration registers; the timeout product is formed at write time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_us_reg       <= '0;
            blank_corner_reg  <= CORNER_NONE;
            never_corner_reg  <= CORNER_NONE;
            screen_right_reg  <= SCREEN_RIGHT_RST;
            screen_bottom_reg <= SCREEN_BOTTOM_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FADE_SECONDS:
                    fade_us_reg <= FADE_US_W'(cfg_data) * FADE_US_W'(US_PER_S);
                CFG_BLANK_NOW_CORNER:   blank_corner_reg  <= cfg_data[2:0];
                CFG_NEVER_BLANK_CORNER: never_corner_reg  <= cfg_data[2:0];
                CFG_SCREEN_RIGHT:       screen_right_reg  <= cfg_data[11:0];
                CFG_SCREEN_BOTTOM:      screen_bottom_reg <= cfg_data[11:0];
                default:
                begin
                end
            endcase
        end
    end

    // blanker state advances as each event is decided
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blanking_reg   <= 1'b0;
            activity_reg   <= '0;
            wake_reg       <= '0;
            col_reg        <= POINTER_RST;
            row_reg        <= POINTER_RST;
            blanker_id_reg <= '0;
        end
        else if (fire)
        begin
            blanking_reg   <= blanking_next;
            activity_reg   <= activity_next;
            wake_reg       <= wake_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            blanker_id_reg <= blanker_id_next;
        end
    end

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                ev_valid_reg <= 1'b1;
            else if (fire)
                ev_valid_reg <= 1'b0;
            if (advance)
                out_valid_reg <= ev_valid_reg;
        end
    end

    // event payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ev_kind_reg     <= kind;
            ev_time_reg     <= time_us;
            ev_x_reg        <= pointer_x;
            ev_y_reg        <= pointer_y;
            ev_move_reg     <= is_mouse_move;
            ev_mods_reg     <= has_modifiers;
            ev_ctrl_reg     <= ctrl_held;
            ev_cmd_reg      <= cmd_held;
            ev_has_char_reg <= has_char;
            ev_char_reg     <= char_code;
            ev_blanker_reg  <= is_blanker_app;
            ev_pid_reg      <= program_id;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            launch_reg <= launch_next;
            pass_reg   <= pass_next;
            quit_reg   <= quit_next;
            qstat_reg  <= qstat_next;
            idle_reg   <= idle_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign launch_blanker = launch_reg;
    assign pass_input     = pass_reg;
    assign send_quit      = quit_reg;
    assign quit_status    = qstat_reg;
    assign blanking       = blanking_reg;
    assign idle_time_us   = idle_reg;

    a_launch_not_blanking: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && launch_blanker |-> !blanking)
        else $error("launch requested while blanking");

    a_quit_needs_blanking: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && send_quit |-> blanking && !quit_status)
        else $error("quit sent without a running blanker");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> ev_valid_reg && out_valid && out_stall)
        else $error("input stalled with room downstream");

    a_event_reaches_output: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("decided event produced no result word");

    a_pass_only_user_input: assert property (@(posedge clk) disable iff (!rst_n)
        fire && ev_kind_reg != KIND_USER_INPUT |=> !pass_input)
        else $error("pass flag set for a non-input event");

endmodule

`default_nettype wire
